// File: hdl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants of the RGB LED strip serializer: item formats,
// configuration set, command format between front and back end.
// ----------------------------------------------------------------------------
package rls_pkg;

    // Parameter defaults
    localparam int MAX_LEDS_DEF   = 1024;
    localparam int GROUP_SIZE_DEF = 4;

    // Command field widths sized for the largest legal MAX_LEDS
    localparam int ADDR_MAXW = 16;
    localparam int CNT_MAXW  = 17;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // Action codes
    localparam logic [2:0] ACT_SET_PIXEL = 3'd0;
    localparam logic [2:0] ACT_SET_GROUP = 3'd1;
    localparam logic [2:0] ACT_FILL      = 3'd2;
    localparam logic [2:0] ACT_START     = 3'd3;
    localparam logic [2:0] ACT_NEXT      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_BAD_STATE = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_STRIP_SIZE = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [2:0] REG_ZERO_LOW   = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd3;
    localparam logic [2:0] REG_ONE_LOW    = 3'd4;

    // Register reset values
    localparam logic [10:0] STRIP_SIZE_RST = 11'd1024;
    localparam logic [7:0]  ZERO_HIGH_RST  = 8'd16;
    localparam logic [7:0]  ZERO_LOW_RST   = 8'd34;
    localparam logic [7:0]  ONE_HIGH_RST   = 8'd32;
    localparam logic [7:0]  ONE_LOW_RST    = 8'd18;

    typedef struct packed {
        logic [2:0] action;
        logic [9:0] position;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       symbol_valid;
        logic [7:0] high_ticks;
        logic [7:0] low_ticks;
        logic       last;
    } rsp_item_t;

    typedef struct packed {
        logic [10:0] strip_size;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_REPLY,
        OP_WRITE,
        OP_START,
        OP_NEXT
    } op_t;

    // Colour is kept in transmit order: green, red, blue
    typedef struct packed {
        op_t                  op;
        logic [1:0]           status;
        logic [ADDR_MAXW-1:0] addr;
        logic [CNT_MAXW-1:0]  count;
        logic [23:0]          colour;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// File: hdl/rls_front.sv
// ----------------------------------------------------------------------------
// rls_front
// Accepts items, checks their arguments against the strip length and turns
// them into commands for the back end.
// ----------------------------------------------------------------------------
module rls_front import rls_pkg::*; #(
    parameter int MAX_LEDS   = MAX_LEDS_DEF,
    parameter int GROUP_SIZE = GROUP_SIZE_DEF,
    localparam int CW        = $clog2(MAX_LEDS + 1)
) (
    input  logic         cmd_valid,
    output logic         cmd_ready,
    input  cmd_item_t    cmd_item,
    input  logic [CW-1:0] strip_len,
    input  back_status_t back_st,
    input  q_status_t    q_st,
    output logic         push,
    output cmd_t         push_cmd
);

    logic [31:0] len32;
    logic [31:0] pos32;
    logic [31:0] first32;

    assign cmd_ready = !q_st.full && !back_st.clearing;
    assign push      = cmd_valid && cmd_ready;

    assign len32   = 32'(strip_len);
    assign pos32   = 32'(cmd_item.position);
    assign first32 = pos32 * GROUP_SIZE;

    always_comb
    begin
        push_cmd        = '0;
        push_cmd.op     = OP_REPLY;
        push_cmd.status = ST_OK;
        push_cmd.colour = {cmd_item.green, cmd_item.red, cmd_item.blue};
        unique case (cmd_item.action)
            ACT_SET_PIXEL:
            begin
                if (pos32 >= len32)
                begin
                    push_cmd.status = ST_BAD_ARG;
                end
                else
                begin
                    push_cmd.op    = OP_WRITE;
                    push_cmd.addr  = ADDR_MAXW'(cmd_item.position);
                    push_cmd.count = CNT_MAXW'(1);
                end
            end
            ACT_SET_GROUP:
            begin
                if (first32 + GROUP_SIZE > len32)
                begin
                    push_cmd.status = ST_BAD_ARG;
                end
                else
                begin
                    push_cmd.op    = OP_WRITE;
                    push_cmd.addr  = ADDR_MAXW'(first32);
                    push_cmd.count = CNT_MAXW'(GROUP_SIZE);
                end
            end
            ACT_FILL:
            begin
                if (strip_len == '0)
                begin
                    push_cmd.status = ST_BAD_STATE;
                end
                else
                begin
                    push_cmd.op    = OP_WRITE;
                    push_cmd.count = CNT_MAXW'(strip_len);
                end
            end
            ACT_START:
            begin
                if (strip_len == '0)
                begin
                    push_cmd.status = ST_BAD_STATE;
                end
                else
                begin
                    push_cmd.op = OP_START;
                end
            end
            ACT_NEXT:
            begin
                push_cmd.op = OP_NEXT;
            end
            default:
            begin
                push_cmd.status = ST_BAD_ARG;
            end
        endcase
    end

endmodule

// File: hdl/rls_queue.sv
// ----------------------------------------------------------------------------
// rls_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module rls_queue import rls_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t q_st
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;

    assign q_st.full  = (fill_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_st.empty = (fill_reg == '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/rls_back.sv
// ----------------------------------------------------------------------------
// rls_back
// Colour store and bit serializer: runs commands from the queue, walks
// store writes, loads LED colours and delivers one result per command.
// ----------------------------------------------------------------------------
module rls_back import rls_pkg::*; #(
    parameter int MAX_LEDS = MAX_LEDS_DEF,
    localparam int AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
    localparam int CW      = $clog2(MAX_LEDS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  q_status_t     q_st,
    output logic          pop,
    input  cmd_t          pop_cmd,
    input  logic [CW-1:0] strip_len,
    input  cfg_t          cfg,
    output back_status_t  back_st,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rsp_item_t     rsp_item
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic          frame_reg, frame_next;
    logic [AW-1:0] led_ptr_reg, led_ptr_next;
    logic [4:0]    bit_ptr_reg, bit_ptr_next;
    logic [23:0]   shift_reg, shift_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   colour_reg, colour_next;
    rsp_item_t     pend_reg, pend_next;
    rsp_item_t     rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [23:0]   colour_store [MAX_LEDS];
    logic [23:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] next_led;
    logic          one_bit;

    assign back_st.clearing = (state_reg == S_CLEAR);
    assign rsp_valid        = rsp_valid_reg;
    assign rsp_item         = rsp_reg;
    assign pop              = (state_reg == S_IDLE) && !q_st.empty;
    assign wr_en            = (state_reg == S_CLEAR) || (state_reg == S_FILL);
    assign next_led         = CW'(led_ptr_reg) + 1'b1;
    assign one_bit          = shift_reg[23];
    assign rd_addr          = (pop_cmd.op == OP_NEXT) ? AW'(next_led) : '0;

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            colour_store[addr_reg] <= colour_reg;
        end
        rd_data_reg <= colour_store[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        led_ptr_next   = led_ptr_reg;
        bit_ptr_next   = bit_ptr_reg;
        shift_next     = shift_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        colour_next    = colour_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                addr_next  = addr_reg + 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    pend_next        = '0;
                    pend_next.status = pop_cmd.status;
                    unique case (pop_cmd.op)
                        OP_REPLY:
                        begin
                            state_next = S_EMIT;
                        end
                        OP_WRITE:
                        begin
                            addr_next   = pop_cmd.addr[AW-1:0];
                            count_next  = pop_cmd.count[CW-1:0];
                            colour_next = pop_cmd.colour;
                            state_next  = S_FILL;
                        end
                        OP_START:
                        begin
                            // Read of LED zero is issued this cycle
                            frame_next   = 1'b1;
                            led_ptr_next = '0;
                            bit_ptr_next = '0;
                            state_next   = S_LOAD;
                        end
                        OP_NEXT:
                        begin
                            if (!frame_reg)
                            begin
                                pend_next.status = ST_BAD_STATE;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                pend_next.symbol_valid = 1'b1;
                                pend_next.high_ticks   = one_bit ? cfg.one_high_ticks
                                                                 : cfg.zero_high_ticks;
                                pend_next.low_ticks    = one_bit ? cfg.one_low_ticks
                                                                 : cfg.zero_low_ticks;
                                shift_next = {shift_reg[22:0], 1'b0};
                                state_next = S_EMIT;
                                if (bit_ptr_reg == 5'd23)
                                begin
                                    bit_ptr_next = '0;
                                    if (next_led >= strip_len)
                                    begin
                                        pend_next.last = 1'b1;
                                        frame_next     = 1'b0;
                                        led_ptr_next   = '0;
                                        shift_next     = '0;
                                    end
                                    else
                                    begin
                                        // Colour of the next LED is read this cycle
                                        led_ptr_next = AW'(next_led);
                                        state_next   = S_LOAD;
                                    end
                                end
                                else
                                begin
                                    bit_ptr_next = bit_ptr_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                addr_next  = addr_reg + 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_LOAD:
            begin
                shift_next = rd_data_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            frame_reg     <= 1'b0;
            led_ptr_reg   <= '0;
            bit_ptr_reg   <= '0;
            shift_reg     <= '0;
            addr_reg      <= '0;
            count_reg     <= CW'(MAX_LEDS);
            colour_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            led_ptr_reg   <= led_ptr_next;
            bit_ptr_reg   <= bit_ptr_next;
            shift_reg     <= shift_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            colour_reg    <= colour_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// File: hdl/rgb_led_strip_serializer.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer
// Colour store and one-wire bit-symbol generator for an addressable RGB LED
// strip, with an APB register port for strip length and bit timing.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_ready/cmd_item) takes one item per
//   handshake: set pixel, set group, fill, start frame or next symbol.
//   Response channel (rsp_valid/rsp_ready/rsp_item) returns exactly one
//   item per command item, in order: a status and, for next symbol, the
//   high and low durations of one bit, green-red-blue, MSB first, with
//   last marking the final bit of the frame.
//   Commands pass a two-entry queue into the back end, which runs one
//   command at a time. A start frame and the symbol that moves on to the
//   next LED pass through a load state that reads that LED's colour; a
//   write walks the store through its write port, one entry per cycle.
//   The response register holds while the receiver stalls; the queue keeps
//   taking items until it is full, then cmd_ready drops.
//   After reset a clearing pass zeroes the store with cmd_ready low;
//   register writes are taken throughout.
//   Write registers only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_led_strip_serializer import rls_pkg::*; #(
    parameter int MAX_LEDS   = MAX_LEDS_DEF,
    parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_item_t   cmd_item,
    // Response channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_item_t   rsp_item,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_LEDS + 1);

    cfg_t          cfg_reg;
    logic          reg_wr;
    logic [2:0]    reg_idx;
    logic [CW-1:0] strip_len;

    q_status_t     q_st;
    back_status_t  back_st;
    logic          push;
    logic          pop;
    cmd_t          push_cmd;
    cmd_t          pop_cmd;

    // Register port: pready is tied high, so a transfer is never held
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strip_size      <= STRIP_SIZE_RST;
            cfg_reg.zero_high_ticks <= ZERO_HIGH_RST;
            cfg_reg.zero_low_ticks  <= ZERO_LOW_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_RST;
            cfg_reg.one_low_ticks   <= ONE_LOW_RST;
        end
        else if (reg_wr)
        begin
            unique case (reg_idx)
                REG_STRIP_SIZE: cfg_reg.strip_size      <= pwdata[10:0];
                REG_ZERO_HIGH:  cfg_reg.zero_high_ticks <= pwdata[7:0];
                REG_ZERO_LOW:   cfg_reg.zero_low_ticks  <= pwdata[7:0];
                REG_ONE_HIGH:   cfg_reg.one_high_ticks  <= pwdata[7:0];
                REG_ONE_LOW:    cfg_reg.one_low_ticks   <= pwdata[7:0];
                default:        ; // drop writes outside the register map
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_STRIP_SIZE: prdata = 32'(cfg_reg.strip_size);
            REG_ZERO_HIGH:  prdata = 32'(cfg_reg.zero_high_ticks);
            REG_ZERO_LOW:   prdata = 32'(cfg_reg.zero_low_ticks);
            REG_ONE_HIGH:   prdata = 32'(cfg_reg.one_high_ticks);
            REG_ONE_LOW:    prdata = 32'(cfg_reg.one_low_ticks);
            default:        prdata = '0;
        endcase
    end

    // Clamp the programmed LED count to the store depth
    always_comb
    begin
        if (32'(cfg_reg.strip_size) > MAX_LEDS)
        begin
            strip_len = CW'(MAX_LEDS);
        end
        else
        begin
            strip_len = CW'(cfg_reg.strip_size);
        end
    end

    rls_front #(
        .MAX_LEDS   (MAX_LEDS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .strip_len (strip_len),
        .back_st   (back_st),
        .q_st      (q_st),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    rls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_st     (q_st)
    );

    rls_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_st      (q_st),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .strip_len (strip_len),
        .cfg       (cfg_reg),
        .back_st   (back_st),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

// File: verif/tb_rgb_led_strip_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_serializer
// Self-checking bench for the LED strip serializer. A queue-fed driver and a
// result monitor run with random pacing. A cycle-free predictor of the color
// store and bit serializer computes the expected status or symbol for every
// item as it is taken. Strip length and bit timing are changed between
// phases over the register port, including empty, single-LED, clamped and
// zero-tick settings.
// ----------------------------------------------------------------------------
module tb_rgb_led_strip_serializer;
    import rls_pkg::*;

    localparam int          MAX_LEDS    = MAX_LEDS_DEF;
    localparam int          GRP         = GROUP_SIZE_DEF;
    localparam int          STALL_LIMIT = 5000;   // quiet cycles before giving up
    localparam int          LONG_HOLD   = 400;    // receiver hold-off, in cycles
    localparam int          HOLD_AT_A   = 300;    // results seen before first hold-off
    localparam int          HOLD_AT_B   = 900;    // results seen before second hold-off
    localparam int          TAIL_CYCLES = 16;
    localparam logic [2:0]  ACT_BAD_LO  = 3'd5;   // undefined action codes
    localparam logic [2:0]  ACT_BAD_HI  = 3'd7;

    typedef enum int {PACE_FLAT, PACE_LIGHT, PACE_FULL} pace_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_item_t   cmd_item  = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_item_t   rsp_item;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    rgb_led_strip_serializer #(
        .MAX_LEDS   (MAX_LEDS),
        .GROUP_SIZE (GRP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 50 MHz bench clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the registers, the color store (kept as
    // R,G,B) and the serializer position.
    // ------------------------------------------------------------------------
    cfg_t        strip_cfg;
    logic [23:0] color_mem [MAX_LEDS];
    logic        frame_on;
    int unsigned led_idx;
    int unsigned bit_idx;
    logic [23:0] wire_word;

    cmd_item_t   cmd_backlog [$];    // items waiting for the driver
    rsp_item_t   rsp_expected [$];   // predicted results, oldest first

    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned symbols_seen    = 0;
    int unsigned frames_done     = 0;
    int unsigned settings_seen   = 1;
    int unsigned errors          = 0;
    int unsigned quiet_cycles    = 0;
    int          tx_wait         = 0;
    int          rx_wait         = 0;
    pace_t       tx_pace         = PACE_FULL;
    pace_t       rx_pace         = PACE_FULL;

    // LEDs in use: the register clamped to the store size
    function automatic int unsigned strip_len();
        if (32'(strip_cfg.strip_size) > 32'(MAX_LEDS))
            return 32'(MAX_LEDS);
        return 32'(strip_cfg.strip_size);
    endfunction

    // Reorder stored R,G,B into the G,R,B order of the wire
    function automatic logic [23:0] wire_order(logic [23:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

    // Apply one item to the predictor and return the result it must produce.
    function automatic rsp_item_t strip_step(cmd_item_t it);
        rsp_item_t   r;
        int unsigned n;
        int unsigned first;
        logic        bit_one;
        r        = '0;
        r.status = ST_OK;
        n        = strip_len();
        first    = 32'(it.position) * 32'(GRP);
        case (it.action)
            ACT_SET_PIXEL:
            begin
                if (32'(it.position) >= n)
                    r.status = ST_BAD_ARG;
                else
                    color_mem[it.position] = {it.red, it.green, it.blue};
            end
            ACT_SET_GROUP:
            begin
                // the whole group must fit inside the strip
                if (n == 0 || first >= n || first + 32'(GRP) > n)
                    r.status = ST_BAD_ARG;
                else
                    for (int unsigned i = 0; i < 32'(GRP); i++)
                        color_mem[first + i] = {it.red, it.green, it.blue};
            end
            ACT_FILL:
            begin
                if (n == 0)
                    r.status = ST_BAD_STATE;
                else
                    for (int unsigned i = 0; i < n; i++)
                        color_mem[i] = {it.red, it.green, it.blue};
            end
            ACT_START:
            begin
                // also restarts a frame in progress from the first LED
                if (n == 0)
                    r.status = ST_BAD_STATE;
                else
                begin
                    frame_on  = 1'b1;
                    led_idx   = 0;
                    bit_idx   = 0;
                    wire_word = wire_order(color_mem[0]);
                end
            end
            ACT_NEXT:
            begin
                if (!frame_on)
                    r.status = ST_BAD_STATE;
                else
                begin
                    bit_one        = wire_word[23];
                    r.symbol_valid = 1'b1;
                    r.high_ticks   = bit_one ? strip_cfg.one_high_ticks
                                             : strip_cfg.zero_high_ticks;
                    r.low_ticks    = bit_one ? strip_cfg.one_low_ticks
                                             : strip_cfg.zero_low_ticks;
                    wire_word      = {wire_word[22:0], 1'b0};
                    if (bit_idx >= 23)
                    begin
                        // end of an LED: a shortened strip ends the frame here
                        if (led_idx + 1 >= n)
                        begin
                            r.last    = 1'b1;
                            frame_on  = 1'b0;
                            led_idx   = 0;
                            bit_idx   = 0;
                            wire_word = '0;
                        end
                        else
                        begin
                            led_idx++;
                            bit_idx   = 0;
                            wire_word = wire_order(color_mem[led_idx]);
                        end
                    end
                    else
                        bit_idx++;
                end
            end
            default:
                r.status = ST_BAD_ARG;
        endcase
        return r;
    endfunction

    function automatic void field_check(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns MISMATCH %s: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare one result against the oldest prediction.
    function automatic void check_rsp(rsp_item_t got);
        rsp_item_t want;
        if (rsp_expected.size() == 0)
        begin
            $display("%0t ns MISMATCH unexpected result: expected none, got %h", $time, got);
            errors++;
        end
        else
        begin
            want = rsp_expected.pop_front();
            if (want.symbol_valid)
                symbols_seen++;
            if (want.last)
                frames_done++;
            field_check("status", 8'(want.status), 8'(got.status));
            field_check("symbol_valid", 8'(want.symbol_valid), 8'(got.symbol_valid));
            field_check("high_ticks", want.high_ticks, got.high_ticks);
            field_check("low_ticks", want.low_ticks, got.low_ticks);
            field_check("last", 8'(want.last), 8'(got.last));
        end
    endfunction

    function automatic int draw_gap(pace_t pace);
        case (pace)
            PACE_FLAT:  return 0;
            PACE_LIGHT: return int'($urandom_range(0, 2));
            default:    return int'($urandom_range(0, 10));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next queued item, hold it until taken, then idle
    // for a drawn number of cycles. Predict each item at its handshake.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        int gap;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_item  <= '0;
            tx_wait   <= 0;
        end
        else
        begin
            gap = tx_wait;
            if (cmd_valid && cmd_ready)
            begin
                rsp_expected.push_back(strip_step(cmd_item));
                items_sent++;
                // switch pacing now and then so flat-out stretches occur too
                if (items_sent % 40 == 0)
                    tx_pace = pace_t'($urandom_range(0, 2));
                gap = draw_gap(tx_pace);
            end
            // hold a pending item untouched until it is taken
            if (!cmd_valid || cmd_ready)
            begin
                if (gap != 0)
                begin
                    cmd_valid <= 1'b0;
                    gap--;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd_item  <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
            tx_wait <= gap;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take results with random back-pressure and check them. Twice
    // in the run, hold off for a long stretch so the block's queue fills and
    // cmd_ready drops while the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int gap;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            gap = rx_wait;
            if (rsp_valid && rsp_ready)
            begin
                check_rsp(rsp_item);
                results_checked++;
                if (results_checked % 40 == 0)
                    rx_pace = pace_t'($urandom_range(0, 2));
                gap = draw_gap(rx_pace);
                if (results_checked == HOLD_AT_A || results_checked == HOLD_AT_B)
                    gap = LONG_HOLD;
            end
            if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                gap--;
            end
            else
                rsp_ready <= 1'b1;
            rx_wait <= gap;
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    // The clearing pass after reset and a full-strip fill stay well below.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t ns timeout: no handshake for %0d cycles, %0d results pending",
                     $time, STALL_LIMIT, rsp_expected.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Register port and stimulus helpers
    // ------------------------------------------------------------------------
    // Two-phase register write; the predictor follows at the write edge.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STRIP_SIZE: strip_cfg.strip_size      = value[10:0];
            REG_ZERO_HIGH:  strip_cfg.zero_high_ticks = value[7:0];
            REG_ZERO_LOW:   strip_cfg.zero_low_ticks  = value[7:0];
            REG_ONE_HIGH:   strip_cfg.one_high_ticks  = value[7:0];
            REG_ONE_LOW:    strip_cfg.one_low_ticks   = value[7:0];
            default: ;
        endcase
    endtask

    // Sample bookkeeping on the falling edge, clear of the driver's updates.
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    // Change strip length and timing once the block has gone idle.
    task automatic set_strip(input logic [10:0] count, input logic [7:0] zero_hi,
                             input logic [7:0] zero_lo, input logic [7:0] one_hi,
                             input logic [7:0] one_lo);
        wait_drained();
        repeat (4) @(posedge clk);
        reg_write(REG_STRIP_SIZE, 32'(count));
        reg_write(REG_ZERO_HIGH, 32'(zero_hi));
        reg_write(REG_ZERO_LOW, 32'(zero_lo));
        reg_write(REG_ONE_HIGH, 32'(one_hi));
        reg_write(REG_ONE_LOW, 32'(one_lo));
        settings_seen++;
    endtask

    function automatic void queue_cmd(logic [2:0] act, logic [9:0] pos, logic [23:0] rgb);
        cmd_item_t it;
        it.action   = act;
        it.position = pos;
        it.red      = rgb[23:16];
        it.green    = rgb[15:8];
        it.blue     = rgb[7:0];
        cmd_backlog.push_back(it);
    endfunction

    function automatic logic [23:0] rand_rgb();
        return 24'($urandom());
    endfunction

    function automatic logic [9:0] rand_pos();
        return 10'($urandom_range(0, 1023));
    endfunction

    // Mostly in range or just past the end, sometimes anywhere.
    function automatic logic [9:0] pixel_pos(int unsigned n);
        if ($urandom_range(0, 4) != 0)
            return 10'($urandom_range(0, (n > 1023) ? 1023 : n));
        return rand_pos();
    endfunction

    function automatic logic [9:0] group_pos(int unsigned n);
        if ($urandom_range(0, 4) != 0)
            return 10'($urandom_range(0, n / 32'(GRP)));
        return rand_pos();
    endfunction

    // Random traffic for the current strip: mostly frames (start, then a run
    // of symbols, often to the end or up to two past it) with writes mixed in, plus
    // stray symbols and noise. Fills of long strips are kept rare.
    function automatic void queue_random(int unsigned count);
        int unsigned n;
        int unsigned queued;
        int unsigned steps;
        int unsigned pick;
        n      = strip_len();
        queued = 0;
        while (queued < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                queue_cmd(ACT_START, rand_pos(), rand_rgb());
                queued++;
                if (n <= 8 && $urandom_range(0, 2) != 0)
                    steps = 24 * n + $urandom_range(0, 2);
                else
                    steps = $urandom_range(1, 60);
                repeat (steps)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        queue_cmd(ACT_SET_PIXEL, pixel_pos(n), rand_rgb());
                    else if (pick < 8)
                        queue_cmd(ACT_SET_GROUP, group_pos(n), rand_rgb());
                    queue_cmd(ACT_NEXT, rand_pos(), rand_rgb());
                    queued++;
                end
            end
            else if (pick < 70)
                queue_cmd(ACT_SET_PIXEL, pixel_pos(n), rand_rgb());
            else if (pick < 82)
                queue_cmd(ACT_SET_GROUP, group_pos(n), rand_rgb());
            else if (pick < 86)
            begin
                if (n <= 64 || $urandom_range(0, 15) == 0)
                    queue_cmd(ACT_FILL, rand_pos(), rand_rgb());
                else
                    queue_cmd(ACT_SET_PIXEL, pixel_pos(n), rand_rgb());
            end
            else if (pick < 92)
                queue_cmd(ACT_NEXT, rand_pos(), rand_rgb());
            else
                queue_cmd(3'($urandom_range(0, 7)), rand_pos(), rand_rgb());
            queued++;
        end
        // often leave a frame running so the next setting cuts into it
        if ($urandom_range(0, 1) != 0)
        begin
            queue_cmd(ACT_START, rand_pos(), rand_rgb());
            repeat ($urandom_range(1, 40))
                queue_cmd(ACT_NEXT, rand_pos(), rand_rgb());
        end
    endfunction

    function automatic logic [7:0] rand_ticks();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        strip_cfg = '{STRIP_SIZE_RST, ZERO_HIGH_RST, ZERO_LOW_RST, ONE_HIGH_RST, ONE_LOW_RST};
        for (int i = 0; i < MAX_LEDS; i++)
            color_mem[i] = '0;
        frame_on  = 1'b0;
        led_idx   = 0;
        bit_idx   = 0;
        wire_word = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Full-length strip at reset timing: symbol with no frame, undefined
        // actions, edge pixels and groups, one fill, restart during a frame,
        // and a write to an LED the frame has not reached yet.
        queue_cmd(ACT_NEXT, '0, '0);
        for (int a = ACT_BAD_LO; a <= ACT_BAD_HI; a++)
            queue_cmd(3'(a), 10'h3FF, 24'hFFFFFF);
        queue_cmd(ACT_SET_PIXEL, 10'd0, 24'hFF0080);
        queue_cmd(ACT_SET_PIXEL, 10'd1023, 24'h01FE7F);
        queue_cmd(ACT_SET_GROUP, 10'd255, 24'h00FF00);
        queue_cmd(ACT_SET_GROUP, 10'd256, 24'hFFFFFF);
        queue_cmd(ACT_FILL, 10'd0, 24'h123456);
        queue_cmd(ACT_SET_PIXEL, 10'd0, 24'hA5C30F);
        queue_cmd(ACT_START, '0, '0);
        repeat (3)
            queue_cmd(ACT_NEXT, '0, '0);
        queue_cmd(ACT_START, 10'h3FF, 24'hFFFFFF);
        repeat (2)
            queue_cmd(ACT_NEXT, '0, '0);
        queue_cmd(ACT_SET_PIXEL, 10'd1, 24'h80FF01);
        queue_random(70);

        // Empty strip with zero timing; the frame left running above drains.
        set_strip(11'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_cmd(ACT_SET_PIXEL, '0, 24'hFFFFFF);
        queue_cmd(ACT_SET_GROUP, '0, 24'hFFFFFF);
        queue_cmd(ACT_FILL, '0, 24'hFFFFFF);
        queue_cmd(ACT_START, '0, '0);
        queue_cmd(ACT_NEXT, '0, '0);
        queue_random(40);

        // Each phase change waits for every result, so the driver pauses
        // with the block fully drained.
        set_strip(11'd1, 8'd1, 8'd255, 8'd255, 8'd1);
        queue_random(130);
        set_strip(11'd2047, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_random(70);
        set_strip(11'd3, rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
        queue_random(150);
        set_strip(11'd4, rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
        queue_random(120);
        set_strip(11'd6, rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
        queue_random(140);
        set_strip(11'd5, ZERO_HIGH_RST, ZERO_LOW_RST, ONE_HIGH_RST, ONE_LOW_RST);
        queue_random(140);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run: %0d items under %0d strip settings, %0d results checked",
                 items_sent, settings_seen, results_checked);
        $display("     %0d bit symbols, %0d frames run to the last bit, %0d errors",
                 symbols_seen, frames_done, errors);
        if (errors == 0 && rsp_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: rgb_led_strip_serializer.f
hdl/rls_pkg.sv
hdl/rls_front.sv
hdl/rls_queue.sv
hdl/rls_back.sv
hdl/rgb_led_strip_serializer.sv
verif/tb_rgb_led_strip_serializer.sv
